// ===== design/terminal_escape_sequence_decoder_core_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef TERMINAL_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define TERMINAL_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk_i outside reset.
`define TESD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder assertion failed");
// Next-cycle implication, checked on clk_i outside reset.
`define TESD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder assertion failed");
`else
`define TESD_ASSERT_IMP(lbl, ante, cons)
`define TESD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/tesd_pkg.sv =====
package tesd_pkg;

  localparam int DEF_PARAM_SLOTS = 10;

  typedef enum logic [5:0] {
    CMD_PRINT   = 6'd1,
    CMD_BELL    = 6'd2,
    CMD_BKSP    = 6'd3,
    CMD_TAB     = 6'd4,
    CMD_CR      = 6'd5,
    CMD_LF      = 6'd6,
    CMD_UP      = 6'd7,
    CMD_DOWN    = 6'd8,
    CMD_FWD     = 6'd9,
    CMD_BACK    = 6'd10,
    CMD_HOME    = 6'd11,
    CMD_REVLF   = 6'd12,
    CMD_GOTO    = 6'd13,
    CMD_EEOS    = 6'd14,
    CMD_EBOS    = 6'd15,
    CMD_CLEAR   = 6'd16,
    CMD_EEOL    = 6'd17,
    CMD_EBOL    = 6'd18,
    CMD_ELINE   = 6'd19,
    CMD_INSL    = 6'd20,
    CMD_DELL    = 6'd21,
    CMD_INSC    = 6'd22,
    CMD_DELC    = 6'd23,
    CMD_MODE    = 6'd24,
    CMD_SCROLL  = 6'd25,
    CMD_SAVE    = 6'd26,
    CMD_RESTORE = 6'd27,
    CMD_REPORT  = 6'd28,
    CMD_RTAB    = 6'd29
  } cmd_e;

  typedef enum logic [2:0] {
    PH_GROUND,
    PH_LEADIN,
    PH_CSI,
    PH_CHARSET,
    PH_V52CMD,
    PH_V52ROW,
    PH_V52COL,
    PH_V52REQ
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH0,
    ST_PUSH1,
    ST_SCAN,
    ST_FIN
  } seq_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
  } res_t;

  typedef struct packed {
    logic push;
    logic fin;
    res_t res;
  } emit_ctl_t;

  // mode ids
  localparam logic [15:0] MODE_INS    = 16'd0;
  localparam logic [15:0] MODE_GRAPH  = 16'd1;
  localparam logic [15:0] MODE_KEYPAD = 16'd2;
  localparam logic [15:0] MODE_INV    = 16'd3;
  localparam logic [15:0] MODE_NOWRAP = 16'd4;
  localparam logic [15:0] MODE_ORIGIN = 16'd5;
  localparam logic [15:0] MODE_AUTOCR = 16'd6;
  localparam logic [15:0] MODE_AUTOLF = 16'd7;

  // report kinds
  localparam logic [15:0] REP_ATTR    = 16'd1;
  localparam logic [15:0] REP_CPOS    = 16'd2;
  localparam logic [15:0] REP_STATUS  = 16'd3;
  localparam logic [15:0] REP_V52POS  = 16'd4;
  localparam logic [15:0] REP_V52ID   = 16'd5;
  localparam logic [15:0] REP_V52ANS  = 16'd6;

  // flag bits
  localparam int FLAG_AUTOCR = 0;
  localparam int FLAG_AUTOLF = 1;
  localparam int FLAG_ORIGIN = 2;

  localparam logic [7:0]  CAN_BYTE   = 8'h18;
  localparam logic [15:0] ERR_CHAR   = 16'd127;
  localparam logic [15:0] DEF_BOTTOM = 16'd24;

  // register indexes
  localparam logic [2:0] REG_NCOL  = 3'd0;
  localparam logic [2:0] REG_NLIN  = 3'd1;
  localparam logic [2:0] REG_SUPP  = 3'd2;
  localparam logic [2:0] REG_STRIP = 3'd3;
  localparam logic [2:0] REG_PASS  = 3'd4;

  function automatic res_t mk_res(cmd_e cmd, logic [15:0] a, logic [15:0] b);
    res_t r;
    r.cmd   = cmd;
    r.arg_a = a;
    r.arg_b = b;
    return r;
  endfunction

  function automatic res_t mk_mode(logic [15:0] id, logic on);
    return mk_res(CMD_MODE, id, {15'b0, on});
  endfunction

  // clamp a signed position into 0 .. size-1
  function automatic logic [7:0] clamp_pos(logic signed [17:0] v, logic [7:0] size);
    logic signed [17:0] lim;
    logic signed [17:0] r;
    lim = $signed({10'b0, size}) - 18'sd1;
    r = v;
    if (r > lim) r = lim;
    if (r < 18'sd0) r = 18'sd0;
    return r[7:0];
  endfunction

endpackage

// ===== design/tesd_emit.sv =====
module tesd_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tesd_pkg::emit_ctl_t ctl_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          command_o,
  output logic [15:0]         arg_a_o,
  output logic [15:0]         arg_b_o,
  output logic                last_o
);
  import tesd_pkg::*;

  // one pending result is held back until we know whether it is the last
  logic pend_v_q, pend_v_d;
  res_t pend_q;
  logic out_v_q, out_v_d;
  res_t out_q;
  logic last_q;
  logic out_free;
  logic move;

  assign out_free = !out_v_q || !out_stall_i;
  assign ready_o  = !pend_v_q || out_free;
  assign move     = pend_v_q && (ctl_i.push || ctl_i.fin);

  always_comb begin
    out_v_d = move ? 1'b1 : (out_v_q && out_stall_i);
    if (ctl_i.push) begin
      pend_v_d = 1'b1;
    end else if (ctl_i.fin) begin
      pend_v_d = 1'b0;
    end else begin
      pend_v_d = pend_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q  <= pend_q;
      last_q <= ctl_i.fin;
    end
    if (ctl_i.push) begin
      pend_q <= ctl_i.res;
    end
  end

  assign out_valid_o = out_v_q;
  assign command_o   = out_q.cmd;
  assign arg_a_o     = out_q.arg_a;
  assign arg_b_o     = out_q.arg_b;
  assign last_o      = last_q;

endmodule

// ===== design/terminal_escape_sequence_decoder_core.sv =====
// Channel   Handshake                Beat
// --------  -----------------------  ------------------------------------
// in        in_valid_i / in_stall_o  in_byte_i
// out       out_valid_o/out_stall_i  command_o arg_a_o arg_b_o last_o
// config    APB psel/penable/pready  paddr pwdata -> prdata
//
// A nonzero byte is accepted and decoded; if it yields results, they are
// pushed and the sequence is closed. CSI h/l/m scan one stored parameter a
// cycle through the shared mode-step unit, unless a result waits on output.
// A zero byte is accepted and dropped.
// rst_ni is asynchronous, active low; no clearing pass is needed.
// Output stalls back up into the result buffer and hold the sequencer.
`include "terminal_escape_sequence_decoder_core_defines.svh"

module terminal_escape_sequence_decoder_core #(
  parameter int PARAM_SLOTS = tesd_pkg::DEF_PARAM_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  command_o,
  output logic [15:0] arg_a_o,
  output logic [15:0] arg_b_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tesd_pkg::*;

  localparam int PIW = $clog2(PARAM_SLOTS);

  // configuration
  logic [7:0] ncol_q, nlin_q;
  logic       supp_q, strip_q, pass_q;

  // sequencer
  seq_e st_q, st_d;
  logic [7:0] byte_q;
  logic [1:0] rn_q;
  res_t r0_q, r1_q;
  logic [7:0] fin_q;
  logic on_q;
  logic [PIW-1:0] scan_i_q, n_q;

  // parser state
  phase_e phase_q, phase_d;
  logic [PIW-1:0] pidx_q, pidx_d;
  logic [7:0]  p0_q, p0_d;
  logic [15:0] p1_q, p1_d, p2_q, p2_d, cur_q, cur_d;
  logic        emul_q, emul_d;
  logic [2:0]  flags_q, flags_d;
  logic [7:0]  stop_q, stop_d;
  logic [7:0]  prow_q, prow_d;

  // parameter store; slot 0 lives in p0_q
  logic [15:0] pstore_q [PARAM_SLOTS];
  logic [PARAM_SLOTS-1:0] pval_q;

  // decode results
  logic        pw_en, pclr, scan_go;
  logic [PIW-1:0] pw_idx;
  logic [15:0] pw_val;
  logic [1:0]  rn;
  res_t        r0, r1;

  // scan step
  logic [15:0] sp;
  logic        hit, step_ok;
  res_t        sres;
  logic        s_emul;
  logic [2:0]  s_flags;

  emit_ctl_t ectl;
  logic      emit_rdy;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_NCOL:  prdata = {24'b0, ncol_q};
      REG_NLIN:  prdata = {24'b0, nlin_q};
      REG_SUPP:  prdata = {31'b0, supp_q};
      REG_STRIP: prdata = {31'b0, strip_q};
      REG_PASS:  prdata = {31'b0, pass_q};
      default:   prdata = '0;
    endcase
  end

  // Decode one byte against the current phase.
  always_comb begin
    logic [7:0]     c;
    logic [PIW-1:0] base;
    logic [PIW:0]   ni;
    logic [15:0]    nv, top, bot;
    logic           errc;
    logic signed [17:0] rowv, colv;
    logic [7:0]     crd;

    c = byte_q;
    phase_d = phase_q;
    pidx_d  = pidx_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    cur_d   = cur_q;
    emul_d  = emul_q;
    stop_d  = stop_q;
    prow_d  = prow_q;
    pw_en   = 1'b0;
    pw_idx  = pidx_q;
    pw_val  = '0;
    pclr    = 1'b0;
    scan_go = 1'b0;
    rn      = 2'd0;
    r0      = mk_res(CMD_PRINT, 16'd0, 16'd0);
    r1      = r0;
    errc    = 1'b0;
    base    = (pidx_q == '0) ? PIW'(1) : pidx_q;
    ni      = {1'b0, base} + (PIW+1)'(1);
    nv      = '0;
    top     = 16'd1;
    bot     = DEF_BOTTOM;
    rowv    = '0;
    colv    = '0;
    crd     = (c < 8'd32) ? 8'd0 : (c - 8'd32);

    case (phase_q)
      PH_GROUND: begin
        if (c inside {[8'h20:8'h7E]}) begin
          r0 = mk_res(CMD_PRINT, {8'b0, c}, 16'd0); rn = 2'd1;
        end else if (c == 8'd7) begin
          r0 = mk_res(CMD_BELL, 16'd0, 16'd0); rn = 2'd1;
        end else if (c == 8'd8) begin
          r0 = mk_res(CMD_BKSP, 16'd0, 16'd0); rn = 2'd1;
        end else if (c == 8'd9) begin
          r0 = mk_res(CMD_TAB, 16'd0, 16'd0); rn = 2'd1;
        end else if (c inside {8'd10, 8'd11, 8'd12}) begin
          if (flags_q[FLAG_AUTOCR]) begin
            r0 = mk_res(CMD_CR, 16'd0, 16'd0);
            r1 = mk_res(CMD_LF, 16'd0, 16'd0); rn = 2'd2;
          end else begin
            r0 = mk_res(CMD_LF, 16'd0, 16'd0); rn = 2'd1;
          end
        end else if (c == 8'd13) begin
          if (flags_q[FLAG_AUTOLF]) begin
            r0 = mk_res(CMD_LF, 16'd0, 16'd0);
            r1 = mk_res(CMD_CR, 16'd0, 16'd0); rn = 2'd2;
          end else begin
            r0 = mk_res(CMD_CR, 16'd0, 16'd0); rn = 2'd1;
          end
        end else if (c inside {8'd14, 8'd15}) begin
          if (!emul_q) begin
            r0 = mk_mode(MODE_GRAPH, c == 8'd14); rn = 2'd1;
          end else if (pass_q) begin
            r0 = mk_res(CMD_PRINT, {8'b0, c}, 16'd0); rn = 2'd1;
          end
        end else if (c == 8'd27) begin
          phase_d = emul_q ? PH_V52CMD : PH_LEADIN;
        end else if (pass_q) begin
          r0 = mk_res(CMD_PRINT, {8'b0, c}, 16'd0); rn = 2'd1;
        end
      end
      PH_LEADIN: begin
        phase_d = PH_GROUND;
        case (c)
          CAN_BYTE: ;
          "(", ")": begin
            phase_d = PH_CHARSET; pidx_d = PIW'(1); p0_d = c;
          end
          "[": begin
            phase_d = PH_CSI; pidx_d = '0; pclr = 1'b1;
            p0_d = '0; p1_d = '0; p2_d = '0; cur_d = '0;
          end
          "7": begin r0 = mk_res(CMD_SAVE, 16'd0, 16'd0); rn = 2'd1; end
          "8": begin r0 = mk_res(CMD_RESTORE, 16'd0, 16'd0); rn = 2'd1; end
          "=": begin r0 = mk_mode(MODE_KEYPAD, 1'b1); rn = 2'd1; end
          ">": begin r0 = mk_mode(MODE_KEYPAD, 1'b0); rn = 2'd1; end
          "D": begin r0 = mk_res(CMD_DOWN, 16'd1, 16'd0); rn = 2'd1; end
          "M": begin r0 = mk_res(CMD_REVLF, 16'd0, 16'd0); rn = 2'd1; end
          "E": begin r0 = mk_res(CMD_LF, 16'd0, 16'd0); rn = 2'd1; end
          default: errc = 1'b1;
        endcase
      end
      PH_CSI: begin
        if (c == ";") begin
          if (ni >= (PIW+1)'(PARAM_SLOTS)) begin
            errc = 1'b1; phase_d = PH_GROUND;
          end else begin
            pidx_d = ni[PIW-1:0];
            pw_en = 1'b1; pw_idx = ni[PIW-1:0]; pw_val = '0; cur_d = '0;
            if (ni == (PIW+1)'(2)) p2_d = '0;
          end
        end else if (c == CAN_BYTE) begin
          phase_d = PH_GROUND;
        end else if (c inside {"?", ">"}) begin
          if (pidx_q == '0 && p0_q == '0) begin
            p0_d = c; pidx_d = PIW'(1); cur_d = '0;
          end else begin
            errc = 1'b1;
          end
        end else if (c inside {["0":"9"]}) begin
          // times ten as shift and add, wraps at 16 bits
          nv = (pidx_q == '0) ? {12'b0, c[3:0]} :
               ((cur_q << 3) + (cur_q << 1) + {12'b0, c[3:0]});
          pidx_d = base; pw_en = 1'b1; pw_idx = base; pw_val = nv; cur_d = nv;
          if ({1'b0, base} == (PIW+1)'(1)) p1_d = nv;
          if ({1'b0, base} == (PIW+1)'(2)) p2_d = nv;
        end else begin
          phase_d = PH_GROUND;
          case (c)
            "H", "f": begin
              if (pidx_q != '0) begin
                colv = ({1'b0, pidx_q} > (PIW+1)'(1)) ?
                       ($signed({2'b0, p2_q}) - 18'sd1) : 18'sd0;
                rowv = $signed({2'b0, p1_q}) - 18'sd1 +
                       (flags_q[FLAG_ORIGIN] ? $signed({10'b0, stop_q}) : 18'sd0);
                r0 = mk_res(CMD_GOTO, {8'b0, clamp_pos(rowv, nlin_q)},
                            {8'b0, clamp_pos(colv, ncol_q)});
              end else begin
                r0 = mk_res(CMD_HOME, 16'd0, 16'd0);
              end
              rn = 2'd1;
            end
            "J": begin
              if (p1_q == 16'd2)      r0 = mk_res(CMD_CLEAR, 16'd0, 16'd0);
              else if (p1_q == 16'd1) r0 = mk_res(CMD_EBOS, 16'd0, 16'd0);
              else                    r0 = mk_res(CMD_EEOS, 16'd0, 16'd0);
              rn = 2'd1;
            end
            "K": begin
              if (p1_q == 16'd2)      r0 = mk_res(CMD_ELINE, 16'd0, 16'd0);
              else if (p1_q == 16'd1) r0 = mk_res(CMD_EBOL, 16'd0, 16'd0);
              else                    r0 = mk_res(CMD_EEOL, 16'd0, 16'd0);
              rn = 2'd1;
            end
            "L": begin r0 = mk_res(CMD_INSL, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "M": begin r0 = mk_res(CMD_DELL, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "A": begin r0 = mk_res(CMD_UP, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "B": begin r0 = mk_res(CMD_DOWN, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "C": begin r0 = mk_res(CMD_FWD, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "D": begin r0 = mk_res(CMD_BACK, (p1_q > 16'd1) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "P": begin r0 = mk_res(CMD_DELC, (p1_q != '0) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "@": begin r0 = mk_res(CMD_INSC, (p1_q != '0) ? p1_q : 16'd1, 16'd0); rn = 2'd1; end
            "c": begin
              if (p0_q != "?") begin
                r0 = mk_res(CMD_REPORT, REP_ATTR, 16'd0); rn = 2'd1;
              end
            end
            "h", "l": scan_go = (pidx_q != '0);
            "m": begin
              if (pidx_q != '0) begin
                scan_go = 1'b1;
              end else begin
                r0 = mk_mode(MODE_INV, 1'b0); rn = 2'd1;
              end
            end
            "n": begin
              if (p1_q == 16'd6) begin
                r0 = mk_res(CMD_REPORT, REP_CPOS, 16'd0); rn = 2'd1;
              end else if (p1_q == 16'd5) begin
                r0 = mk_res(CMD_REPORT, REP_STATUS, 16'd0); rn = 2'd1;
              end else begin
                errc = 1'b1;
              end
            end
            "r": begin
              if ({1'b0, pidx_q} >= (PIW+1)'(2) && p2_q != '0) begin
                top = p1_q; bot = p2_q;
              end
              stop_d = (top == '0) ? 8'd0 :
                       ((top > 16'd256) ? 8'hFF : 8'(top - 16'd1));
              r0 = mk_res(CMD_SCROLL, top, bot);
              r1 = mk_res(CMD_HOME, 16'd0, 16'd0);
              rn = 2'd2;
            end
            "s": begin r0 = mk_res(CMD_SAVE, 16'd0, 16'd0); rn = 2'd1; end
            "u": begin r0 = mk_res(CMD_RESTORE, 16'd0, 16'd0); rn = 2'd1; end
            default: errc = 1'b1;
          endcase
        end
      end
      PH_CHARSET: begin
        phase_d = PH_GROUND;
        if (p0_q == "(") begin
          if (c == "B") begin
            r0 = mk_mode(MODE_GRAPH, 1'b0); rn = 2'd1;
          end else if (c == "0") begin
            r0 = mk_mode(MODE_GRAPH, 1'b1); rn = 2'd1;
          end
        end
      end
      PH_V52CMD: begin
        phase_d = PH_GROUND;
        rn = 2'd1;
        case (c)
          "Y": begin phase_d = PH_V52ROW; rn = 2'd0; end
          "i": begin phase_d = PH_V52REQ; rn = 2'd0; end
          "<": begin emul_d = 1'b0; rn = 2'd0; end
          "A": r0 = mk_res(CMD_UP, 16'd1, 16'd0);
          "B": r0 = mk_res(CMD_DOWN, 16'd1, 16'd0);
          "C": r0 = mk_res(CMD_FWD, 16'd1, 16'd0);
          "D": r0 = mk_res(CMD_BKSP, 16'd0, 16'd0);
          "H": r0 = mk_res(CMD_HOME, 16'd0, 16'd0);
          "I": r0 = mk_res(CMD_REVLF, 16'd0, 16'd0);
          "j": r0 = mk_res(CMD_SAVE, 16'd0, 16'd0);
          "k": r0 = mk_res(CMD_RESTORE, 16'd0, 16'd0);
          "n": r0 = mk_res(CMD_REPORT, REP_V52POS, 16'd0);
          "-": r0 = mk_res(CMD_RTAB, 16'd0, 16'd0);
          "E": r0 = mk_res(CMD_CLEAR, 16'd1, 16'd0);
          "b": r0 = mk_res(CMD_EBOS, 16'd0, 16'd0);
          "J": r0 = mk_res(CMD_EEOS, 16'd0, 16'd0);
          "l": begin
            r0 = mk_res(CMD_CLEAR, 16'd0, 16'd0);
            r1 = mk_res(CMD_EBOL, 16'd0, 16'd0);
            rn = 2'd2;
          end
          "o": r0 = mk_res(CMD_EBOL, 16'd0, 16'd0);
          "K": r0 = mk_res(CMD_EEOL, 16'd0, 16'd0);
          "L": r0 = mk_res(CMD_INSL, 16'd1, 16'd0);
          "M": r0 = mk_res(CMD_DELL, 16'd1, 16'd0);
          "N": r0 = mk_res(CMD_DELC, 16'd1, 16'd0);
          "@": r0 = mk_mode(MODE_INS, 1'b1);
          "O": r0 = mk_mode(MODE_INS, 1'b0);
          "=": r0 = mk_mode(MODE_KEYPAD, 1'b1);
          ">": r0 = mk_mode(MODE_KEYPAD, 1'b0);
          "p": r0 = mk_mode(MODE_INV, 1'b1);
          "q": r0 = mk_mode(MODE_INV, 1'b0);
          "v": r0 = mk_mode(MODE_NOWRAP, 1'b0);
          "w": r0 = mk_mode(MODE_NOWRAP, 1'b1);
          "Z": r0 = mk_res(CMD_REPORT, REP_V52ID, 16'd0);
          default: rn = 2'd0;
        endcase
      end
      PH_V52ROW: begin
        prow_d  = clamp_pos($signed({10'b0, crd}), nlin_q);
        phase_d = PH_V52COL;
      end
      PH_V52COL: begin
        phase_d = PH_GROUND;
        r0 = mk_res(CMD_GOTO, {8'b0, prow_q},
                    {8'b0, clamp_pos($signed({10'b0, crd}), ncol_q)});
        rn = 2'd1;
      end
      PH_V52REQ: begin
        phase_d = PH_GROUND;
        if (c == "0") begin
          r0 = mk_res(CMD_REPORT, REP_V52ANS, 16'd0); rn = 2'd1;
        end
      end
      default: phase_d = PH_GROUND;
    endcase

    if (errc && !supp_q) begin
      r0 = mk_res(CMD_PRINT, ERR_CHAR, 16'd0);
      rn = 2'd1;
    end
  end

  // Mode-step unit: one stored parameter per cycle, unless a hit waits on the emitter.
  always_comb begin
    sp      = pval_q[scan_i_q] ? pstore_q[scan_i_q] : 16'd0;
    hit     = 1'b0;
    sres    = mk_mode(MODE_INV, 1'b0);
    s_emul  = emul_q;
    s_flags = flags_q;
    if (fin_q == "m") begin
      if (sp == 16'd7) begin
        hit = 1'b1; sres = mk_mode(MODE_INV, 1'b1);
      end else if (sp == 16'd0) begin
        hit = 1'b1; sres = mk_mode(MODE_INV, 1'b0);
      end
    end else begin
      case (p0_q)
        8'h00: begin
          if (sp == 16'd4) begin
            hit = 1'b1; sres = mk_mode(MODE_INS, on_q);
          end
        end
        "?": begin
          if (sp == 16'd2) begin
            s_emul = 1'b1;
          end else if (sp == 16'd6) begin
            hit = 1'b1; sres = mk_mode(MODE_ORIGIN, on_q);
            s_flags[FLAG_ORIGIN] = on_q;
          end else if (sp == 16'd7) begin
            hit = 1'b1; sres = mk_mode(MODE_NOWRAP, !on_q);
          end else if (sp == 16'd20) begin
            hit = 1'b1; sres = mk_mode(MODE_AUTOCR, on_q);
            s_flags[FLAG_AUTOCR] = on_q;
          end
        end
        ">": begin
          if (sp == 16'd8) begin
            hit = 1'b1; sres = mk_mode(MODE_AUTOLF, on_q);
            s_flags[FLAG_AUTOLF] = on_q;
          end else if (sp == 16'd9) begin
            hit = 1'b1; sres = mk_mode(MODE_AUTOCR, on_q);
            s_flags[FLAG_AUTOCR] = on_q;
          end
        end
        default: ;
      endcase
    end
    step_ok = !hit || emit_rdy;
  end

  // Flag updates come from the mode-step unit only; emulation updates also come from decode.
  always_comb begin
    flags_d = flags_q;
    if (st_q == ST_SCAN && step_ok) begin
      flags_d = s_flags;
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_byte_i != 8'h00) st_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (scan_go)          st_d = ST_SCAN;
        else if (rn != 2'd0)  st_d = ST_PUSH0;
        else                  st_d = ST_IDLE;
      end
      ST_PUSH0: begin
        if (emit_rdy) st_d = (rn_q == 2'd2) ? ST_PUSH1 : ST_FIN;
      end
      ST_PUSH1: begin
        if (emit_rdy) st_d = ST_FIN;
      end
      ST_SCAN: begin
        if (step_ok && scan_i_q == n_q) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (emit_rdy) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (st_q != ST_IDLE);
    ectl.push  = 1'b0;
    ectl.fin   = 1'b0;
    ectl.res   = r0_q;
    case (st_q)
      ST_PUSH0: ectl.push = emit_rdy;
      ST_PUSH1: begin
        ectl.push = emit_rdy;
        ectl.res  = r1_q;
      end
      ST_SCAN: begin
        ectl.push = hit && emit_rdy;
        ectl.res  = sres;
      end
      ST_FIN:  ectl.fin = emit_rdy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      phase_q  <= PH_GROUND;
      pidx_q   <= '0;
      p0_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
      cur_q    <= '0;
      emul_q   <= 1'b0;
      flags_q  <= '0;
      stop_q   <= '0;
      prow_q   <= '0;
      pval_q   <= '0;
      rn_q     <= '0;
      scan_i_q <= '0;
      n_q      <= '0;
      ncol_q   <= 8'd80;
      nlin_q   <= 8'd24;
      supp_q   <= 1'b0;
      strip_q  <= 1'b0;
      pass_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      flags_q <= flags_d;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_NCOL:  ncol_q  <= pwdata[7:0];
          REG_NLIN:  nlin_q  <= pwdata[7:0];
          REG_SUPP:  supp_q  <= pwdata[0];
          REG_STRIP: strip_q <= pwdata[0];
          REG_PASS:  pass_q  <= pwdata[0];
          default: ;
        endcase
      end
      if (st_q == ST_DECODE) begin
        phase_q <= phase_d;
        pidx_q  <= pidx_d;
        p0_q    <= p0_d;
        p1_q    <= p1_d;
        p2_q    <= p2_d;
        cur_q   <= cur_d;
        emul_q  <= emul_d;
        stop_q  <= stop_d;
        prow_q  <= prow_d;
        rn_q    <= rn;
        n_q     <= pidx_q;
        scan_i_q <= PIW'(1);
        if (pclr) begin
          pval_q <= '0;
        end else if (pw_en) begin
          pval_q[pw_idx] <= 1'b1;
        end
      end else if (st_q == ST_SCAN && step_ok) begin
        emul_q   <= s_emul;
        scan_i_q <= scan_i_q + PIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      byte_q <= strip_q ? {1'b0, in_byte_i[6:0]} : in_byte_i;
    end
    if (st_q == ST_DECODE) begin
      r0_q  <= r0;
      r1_q  <= r1;
      fin_q <= byte_q;
      on_q  <= (byte_q == "h");
      if (pw_en) pstore_q[pw_idx] <= pw_val;
    end
  end

  tesd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ectl),
    .ready_o     (emit_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .command_o   (command_o),
    .arg_a_o     (arg_a_o),
    .arg_b_o     (arg_b_o),
    .last_o      (last_o)
  );

  // An accepted nonzero byte always occupies the sequencer next cycle.
  `TESD_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o && (in_byte_i != 8'h00), in_stall_o)
  // The scan walks slots 1 .. n only.
  `TESD_ASSERT_IMP(a_scan_range, st_q == ST_SCAN, (scan_i_q != '0) && (scan_i_q <= n_q))
  // An open CSI never holds an index past the last slot.
  `TESD_ASSERT_IMP(a_pidx_range, phase_q == PH_CSI, ({1'b0, pidx_q} < (PIW+1)'(PARAM_SLOTS)))

endmodule
